[sv/pec_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and pipeline types for the polynomial easing curve.
package pec_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_WIDTH  = FRAC_BITS + 1;
   localparam int PROD_WIDTH  = 2 * WORD_WIDTH;
   localparam int MUL_STAGES  = 4;
   localparam int STEP_WIDTH  = 3;
   localparam int CSR_WIDTH   = 3;
   localparam int CSR_IDX_W   = 1;

   localparam logic [WORD_WIDTH-1:0] ONE  = WORD_WIDTH'(1) << FRAC_BITS;
   localparam logic [WORD_WIDTH-1:0] HALF = WORD_WIDTH'(1) << (FRAC_BITS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_KIND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE     = 1'd1;

   localparam logic [CSR_WIDTH-1:0] KIND_LINEAR = 3'd0;
   localparam logic [CSR_WIDTH-1:0] KIND_IN     = 3'd1;
   localparam logic [CSR_WIDTH-1:0] KIND_OUT    = 3'd2;
   localparam logic [CSR_WIDTH-1:0] KIND_IN_OUT = 3'd3;
   localparam logic [CSR_WIDTH-1:0] KIND_OUT_IN = 3'd4;

   localparam logic [CSR_WIDTH-1:0] DEGREE_RESET = 3'd2;
   localparam logic [CSR_WIDTH-1:0] DEGREE_MIN   = 3'd2;
   localparam logic [CSR_WIDTH-1:0] DEGREE_MAX   = 3'd5;

   typedef enum logic [2:0] {
      POST_PLAIN,
      POST_INV,
      POST_HALF,
      POST_INV_HALF,
      POST_HALF_INV,
      POST_HALF_UP
   } post_type;

   typedef struct packed {
      logic                  valid;
      logic [STEP_WIDTH-1:0] steps;
      post_type              post;
      logic [WORD_WIDTH-1:0] base;
      logic [WORD_WIDTH-1:0] power;
   } stage_type;

endpackage

[sv/pec_mul_stage.sv]
`timescale 1ns / 1ps
// One registered Q-format multiply step of the power chain.
module pec_mul_stage (
   input  logic              clock,
   input  logic              reset,
   input  pec_pkg::stage_type stage_in,
   output pec_pkg::stage_type stage_out
);
   import pec_pkg::*;

   logic [PROD_WIDTH-1:0] prod;
   stage_type             stage_in_w;
   stage_type             stage_ff;

   always_comb begin
      prod = PROD_WIDTH'(stage_in.power) * PROD_WIDTH'(stage_in.base)
             + PROD_WIDTH'(HALF);
      stage_in_w = stage_in;
      if (stage_in.steps != '0) begin
         stage_in_w.power = prod[FRAC_BITS +: WORD_WIDTH];
         stage_in_w.steps = stage_in.steps - STEP_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

[sv/polynomial_easing_curve.sv]
`timescale 1ns / 1ps
// Top level: polynomial easing curve, Q16 progress in, Q16 eased value out.
//
// Usage:
//   A transaction enters when start is high and busy is low. busy is always
//   low, so a new progress value can be issued on every clock.
//   Each result appears on rsp_eased for exactly one cycle with rsp_valid
//   high, after the entry, four multiply and output registers, in issue order.
//   Throughput is one transaction per cycle: the base select, four
//   17x17 multiply stages and the final adjust stage are fully pipelined.
//   curve_kind (index 0) and degree (index 1) are written through
//   csr_write_enable/csr_index/csr_data; write them only while no
//   transaction is in flight.
//   Reset clears the pipeline valid bits and sets curve_kind to linear and
//   degree to 2. The receiver cannot stall, so there is no back pressure.
module polynomial_easing_curve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pec_pkg::WORD_WIDTH-1:0]      req_progress,
   output logic                                rsp_valid,
   output logic [pec_pkg::WORD_WIDTH-1:0]      rsp_eased,
   input  logic                                csr_write_enable,
   input  logic [pec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pec_pkg::CSR_WIDTH-1:0]       csr_data
);
   import pec_pkg::*;

   logic [CSR_WIDTH-1:0]  kind_ff;
   logic [CSR_WIDTH-1:0]  degree_ff;
   logic [CSR_WIDTH-1:0]  degree_eff;
   logic [WORD_WIDTH-1:0] u;
   logic [WORD_WIDTH-1:0] one_minus_u;
   logic [WORD_WIDTH-1:0] half_minus_u;
   logic [WORD_WIDTH-1:0] u_minus_half;
   logic                  low_half;
   stage_type             entry_in;
   stage_type             entry_ff;
   stage_type             chain [MUL_STAGES+1];
   stage_type             last;
   logic [WORD_WIDTH-1:0] p_half;
   logic [WORD_WIDTH-1:0] eased_in;
   logic [WORD_WIDTH-1:0] eased_ff;
   logic                  valid_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_LINEAR;
         degree_ff <= DEGREE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CURVE_KIND: kind_ff   <= csr_data;
            CSR_DEGREE:     degree_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   always_comb begin
      if (degree_ff < DEGREE_MIN) begin
         degree_eff = DEGREE_MIN;
      end else if (degree_ff > DEGREE_MAX) begin
         degree_eff = DEGREE_MAX;
      end else begin
         degree_eff = degree_ff;
      end
   end

   // stage 0: clamp and pick the base of the power
   always_comb begin
      u            = (req_progress > ONE) ? ONE : req_progress;
      one_minus_u  = ONE - u;
      half_minus_u = HALF - u;
      u_minus_half = u - HALF;
      low_half     = (u < HALF);

      entry_in.valid = start;
      entry_in.steps = STEP_WIDTH'(degree_eff - CSR_WIDTH'(1));
      entry_in.post  = POST_PLAIN;
      entry_in.base  = u;
      case (kind_ff)
         KIND_IN: begin
            entry_in.base = u;
         end
         KIND_OUT: begin
            entry_in.base = one_minus_u;
            entry_in.post = POST_INV;
         end
         KIND_IN_OUT: begin
            if (low_half) begin
               entry_in.base = {u[WORD_WIDTH-2:0], 1'b0};
               entry_in.post = POST_HALF;
            end else begin
               entry_in.base = {one_minus_u[WORD_WIDTH-2:0], 1'b0};
               entry_in.post = POST_INV_HALF;
            end
         end
         KIND_OUT_IN: begin
            if (low_half) begin
               entry_in.base = {half_minus_u[WORD_WIDTH-2:0], 1'b0};
               entry_in.post = POST_HALF_INV;
            end else begin
               entry_in.base = {u_minus_half[WORD_WIDTH-2:0], 1'b0};
               entry_in.post = POST_HALF_UP;
            end
         end
         default: begin
            entry_in.steps = '0;
         end
      endcase
      entry_in.power = entry_in.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar i = 0; i < MUL_STAGES; i++) begin : g_mul
      pec_mul_stage u_mul (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign last = chain[MUL_STAGES];

   // final adjust: inversion, halving and offset
   always_comb begin
      p_half = last.power >> 1;
      case (last.post)
         POST_PLAIN:    eased_in = last.power;
         POST_INV:      eased_in = ONE - last.power;
         POST_HALF:     eased_in = p_half;
         POST_INV_HALF: eased_in = ONE - p_half;
         POST_HALF_INV: eased_in = (ONE - last.power) >> 1;
         POST_HALF_UP:  eased_in = p_half + HALF;
         default:       eased_in = last.power;
      endcase
   end

   always_ff @(posedge clock) begin
      eased_ff <= eased_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_eased = eased_ff;

endmodule
